// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands on clk with reset rst_n active low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/nsrg_pkg.sv =====
// ---------------------------------------------------------------------------
// nsrg_pkg
// shared types and constants of the natural selection run generator
// ---------------------------------------------------------------------------
`default_nettype none

package nsrg_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int KEY_W      = 32;
    localparam int TAG_W      = 16;
    localparam int RUN_W      = 16;
    localparam int CFG_W      = 5;
    localparam int CNT_W      = 6;
    localparam int FILL_W     = 5;
    localparam int ACTIVE_RST = 16;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } item_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic [TAG_W-1:0]        out_tag;
        logic [RUN_W-1:0]        run_index;
        logic                    run_last;
        logic                    last;
    } result_t;

    typedef logic [CFG_W-1:0] cfg_word_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } chain_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_EMIT,
        S_FLUSH_RES,
        S_SWAP_RD,
        S_SWAP_INS,
        S_FLUSH_END,
        S_FLUSH_TAIL
    } state_t;

endpackage

`default_nettype wire

// ===== sv/nsrg_stream_if.sv =====
// ---------------------------------------------------------------------------
// nsrg_stream_if
// valid/ready channel carrying one word of type T
// ---------------------------------------------------------------------------
`default_nettype none

interface nsrg_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/nsrg_cell.sv =====
// ---------------------------------------------------------------------------
// nsrg_cell
// one entry of the sorted chain: insert shifts down, pop shifts up
// ---------------------------------------------------------------------------
`default_nettype none

module nsrg_cell
    import nsrg_pkg::*;
#(
    parameter int SLOT_W = 4,
    localparam int ENT_W = 1 + KEY_W + TAG_W + SLOT_W
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire chain_op_t        op,
    input  wire logic [ENT_W-1:0] new_ent,
    input  wire logic [ENT_W-1:0] prev_ent,
    input  wire logic             prev_lt,
    input  wire logic [ENT_W-1:0] next_ent,
    output logic [ENT_W-1:0]      cur_ent,
    output logic                  lt
);

    typedef struct packed {
        logic                    v;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic [SLOT_W-1:0]       slot;
    } ent_t;

    ent_t n;
    ent_t c;
    ent_t nx;
    logic valid_reg;
    logic [ENT_W-2:0] data_reg;

    assign n       = ent_t'(new_ent);
    assign c       = ent_t'({valid_reg, data_reg});
    assign cur_ent = {valid_reg, data_reg};

    // order is key first, slot number breaks ties
    assign lt = !c.v || (n.key < c.key) || ((n.key == c.key) && (n.slot < c.slot));

    always_comb
    begin
        nx = c;
        if (op.pop)
        begin
            nx = ent_t'(next_ent);
        end
        else if (op.ins)
        begin
            if (prev_lt)
            begin
                nx = ent_t'(prev_ent);
            end
            else if (lt)
            begin
                nx = n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= nx.v;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= nx[ENT_W-2:0];
    end

endmodule

`default_nettype wire

// ===== sv/nsrg_chain.sv =====
// ---------------------------------------------------------------------------
// nsrg_chain
// row of cells kept in ascending order, minimum always in the head cell
// ---------------------------------------------------------------------------
`default_nettype none

module nsrg_chain
    import nsrg_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int SLOT_W = 4,
    localparam int ENT_W = 1 + KEY_W + TAG_W + SLOT_W
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire chain_op_t        op,
    input  wire logic [ENT_W-1:0] new_ent,
    output logic [ENT_W-1:0]      head,
    output logic                  second_v
);

    logic [ENT_W-1:0] ent [SLOTS];
    logic             lt  [SLOTS];

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic [ENT_W-1:0] prev_e;
        logic [ENT_W-1:0] next_e;
        logic             prev_l;

        if (i == 0)
        begin : g_first
            assign prev_e = '0;
            assign prev_l = 1'b0;
        end
        else
        begin : g_mid
            assign prev_e = ent[i-1];
            assign prev_l = lt[i-1];
        end

        if (i == SLOTS - 1)
        begin : g_end
            assign next_e = '0;
        end
        else
        begin : g_inner
            assign next_e = ent[i+1];
        end

        nsrg_cell #(
            .SLOT_W (SLOT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (op),
            .new_ent  (new_ent),
            .prev_ent (prev_e),
            .prev_lt  (prev_l),
            .next_ent (next_e),
            .cur_ent  (ent[i]),
            .lt       (lt[i])
        );
    end

    assign head     = ent[0];
    assign second_v = ent[1][ENT_W-1];

endmodule

`default_nettype wire

// ===== sv/natural_selection_run_generator.sv =====
// an accepted record is registered and dispatched to the chain or the reservoir; a word it
// causes is popped from the chain head into the output register; no new record is taken
// until back in idle; a run flush pops stored records, a reservoir swap reads and inserts them,
// both one at a time, paced by the single pop or insert port of the cell chain
// reset: memory empty, counters zero, no hole, active_slots = 16
// ---------------------------------------------------------------------------
// natural_selection_run_generator
// sorted run generation by natural selection over a chain of sorted cells
// ---------------------------------------------------------------------------
`default_nettype none

module natural_selection_run_generator
    import nsrg_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    nsrg_stream_if.sink   items,
    nsrg_stream_if.source results,
    nsrg_stream_if.sink   cfg
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ENT_W  = 1 + KEY_W + TAG_W + SLOT_W;
    localparam logic [FILL_W-1:0] FILL_MAX = '1;

    typedef struct packed {
        logic                    v;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic [SLOT_W-1:0]       slot;
    } ent_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]        active_reg;
    logic                    func_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [CNT_W-1:0]        rcnt_reg, rcnt_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [SLOT_W-1:0]       hole_reg, hole_next;
    logic                    hole_none_reg, hole_none_next;
    logic signed [KEY_W-1:0] last_key_reg, last_key_next;
    logic [RUN_W-1:0]        run_reg, run_next;
    logic [SLOTS-1:0]        vbits_reg, vbits_next;
    logic                    popped_reg, popped_next;
    logic                    final_reg, final_next;
    logic                    ov_reg;
    result_t                 od_reg;

    logic [KEY_W+TAG_W-1:0] res_mem [SLOTS];
    logic [KEY_W+TAG_W-1:0] res_rd_reg;

    logic [CNT_W-1:0]  eff;
    logic [FILL_W-1:0] fill_inc;
    logic [CNT_W-1:0]  rcnt_inc;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic              ge_last;
    logic              swap_done;
    logic              pop_ok;
    logic              pop_do;
    logic              res_we;
    chain_op_t         op;
    ent_t              new_e;
    ent_t              head;
    logic [ENT_W-1:0]  head_vec;
    logic              second_v;
    result_t           word;

    nsrg_chain #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .new_ent  (ENT_W'(new_e)),
        .head     (head_vec),
        .second_v (second_v)
    );

    assign head = ent_t'(head_vec);

    // out of range register values clamp to 1 .. SLOTS
    always_comb
    begin
        if (active_reg == '0)
        begin
            eff = CNT_W'(1);
        end
        else if (CNT_W'(active_reg) > CNT_W'(SLOTS))
        begin
            eff = CNT_W'(SLOTS);
        end
        else
        begin
            eff = CNT_W'(active_reg);
        end
    end

    assign fill_inc  = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + 1'b1;
    assign rcnt_inc  = (rcnt_reg < CNT_W'(SLOTS)) ? rcnt_reg + 1'b1 : rcnt_reg;
    assign ge_last   = key_reg >= last_key_reg;
    assign swap_done = idx_reg == rcnt_reg;
    assign pop_ok    = !ov_reg || results.ready;

    // lowest empty slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!vbits_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (func_reg)
                begin
                    state_next = S_FLUSH_END;
                end
                else if (hole_none_reg)
                begin
                    if (!free_found || ({1'b0, fill_inc} >= eff))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (ge_last)
                begin
                    state_next = S_EMIT;
                end
                else if (rcnt_inc >= eff)
                begin
                    state_next = S_FLUSH_RES;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (!head.v || pop_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FLUSH_RES, S_FLUSH_END:
            begin
                if (!head.v)
                begin
                    state_next = S_SWAP_RD;
                end
            end
            S_SWAP_RD:
            begin
                if (!swap_done)
                begin
                    state_next = S_SWAP_INS;
                end
                else if (final_reg)
                begin
                    state_next = S_FLUSH_TAIL;
                end
                else if (rcnt_reg >= eff)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWAP_INS:
            begin
                state_next = S_SWAP_RD;
            end
            S_FLUSH_TAIL:
            begin
                if (!head.v)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and chain control
    always_comb
    begin
        op       = '0;
        new_e    = '0;
        pop_do   = 1'b0;
        res_we   = 1'b0;
        word.out_key   = head.key;
        word.out_tag   = head.tag;
        word.run_index = run_reg;
        word.run_last  = !second_v;
        word.last      = 1'b0;
        case (state_reg)
            S_DISPATCH:
            begin
                if (!func_reg && hole_none_reg && free_found)
                begin
                    op.ins = 1'b1;
                    new_e  = '{v: 1'b1, key: key_reg, tag: tag_reg, slot: free_slot};
                end
                else if (!func_reg && !hole_none_reg && ge_last)
                begin
                    op.ins = 1'b1;
                    new_e  = '{v: 1'b1, key: key_reg, tag: tag_reg, slot: hole_reg};
                end
                else if (!func_reg && !hole_none_reg)
                begin
                    res_we = rcnt_reg < CNT_W'(SLOTS);
                end
            end
            S_EMIT:
            begin
                pop_do         = head.v && pop_ok;
                word.run_last  = 1'b0;
                word.last      = 1'b1;
            end
            S_FLUSH_RES:
            begin
                pop_do = head.v && pop_ok;
            end
            S_FLUSH_END:
            begin
                pop_do    = head.v && pop_ok;
                word.last = !second_v && (rcnt_reg == '0);
            end
            S_FLUSH_TAIL:
            begin
                pop_do    = head.v && pop_ok;
                word.last = !second_v;
            end
            S_SWAP_INS:
            begin
                op.ins = 1'b1;
                new_e  = '{v: 1'b1, key: res_rd_reg[KEY_W+TAG_W-1:TAG_W],
                           tag: res_rd_reg[TAG_W-1:0], slot: idx_reg[SLOT_W-1:0]};
            end
            default:
            begin
            end
        endcase
        op.pop = pop_do;
    end

    assign items.ready = state_reg == S_IDLE;
    assign cfg.ready   = 1'b1;
    assign results.valid = ov_reg;
    assign results.data  = od_reg;

    // datapath register updates
    always_comb
    begin
        fill_next      = fill_reg;
        rcnt_next      = rcnt_reg;
        idx_next       = idx_reg;
        hole_next      = hole_reg;
        hole_none_next = hole_none_reg;
        last_key_next  = last_key_reg;
        run_next       = run_reg;
        vbits_next     = vbits_reg;
        popped_next    = popped_reg;
        final_next     = final_reg;

        if (op.ins)
        begin
            vbits_next[new_e.slot] = 1'b1;
        end
        if (pop_do)
        begin
            vbits_next[head.slot] = 1'b0;
            last_key_next         = head.key;
            popped_next           = 1'b1;
        end

        case (state_reg)
            S_DISPATCH:
            begin
                idx_next    = '0;
                popped_next = 1'b0;
                if (!func_reg && hole_none_reg && free_found)
                begin
                    fill_next = fill_inc;
                end
                if (res_we)
                begin
                    rcnt_next = rcnt_inc;
                end
            end
            S_EMIT:
            begin
                if (!head.v)
                begin
                    hole_none_next = 1'b1;
                end
                else if (pop_ok)
                begin
                    hole_next      = head.slot;
                    hole_none_next = 1'b0;
                end
            end
            S_FLUSH_RES:
            begin
                if (!head.v)
                begin
                    final_next = 1'b0;
                    if (run_reg != '1)
                    begin
                        run_next = run_reg + 1'b1;
                    end
                end
            end
            S_FLUSH_END:
            begin
                if (!head.v)
                begin
                    final_next = 1'b1;
                    if (popped_reg && (run_reg != '1))
                    begin
                        run_next = run_reg + 1'b1;
                    end
                end
            end
            S_SWAP_RD:
            begin
                if (swap_done)
                begin
                    fill_next      = rcnt_reg[FILL_W-1:0];
                    rcnt_next      = '0;
                    hole_none_next = 1'b1;
                end
            end
            S_SWAP_INS:
            begin
                idx_next = idx_reg + 1'b1;
            end
            S_FLUSH_TAIL:
            begin
                if (!head.v)
                begin
                    fill_next      = '0;
                    rcnt_next      = '0;
                    hole_none_next = 1'b1;
                    last_key_next  = '0;
                    run_next       = '0;
                    vbits_next     = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= CFG_W'(ACTIVE_RST);
            fill_reg      <= '0;
            rcnt_reg      <= '0;
            idx_reg       <= '0;
            hole_none_reg <= 1'b1;
            last_key_reg  <= '0;
            run_reg       <= '0;
            vbits_reg     <= '0;
            popped_reg    <= 1'b0;
            final_reg     <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rcnt_reg      <= rcnt_next;
            idx_reg       <= idx_next;
            hole_none_reg <= hole_none_next;
            last_key_reg  <= last_key_next;
            run_reg       <= run_next;
            vbits_reg     <= vbits_next;
            popped_reg    <= popped_next;
            final_reg     <= final_next;
            if (cfg.valid)
            begin
                active_reg <= cfg.data;
            end
            if (pop_do)
            begin
                ov_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hole_reg <= hole_next;
        if (items.valid && items.ready)
        begin
            func_reg <= items.data.func;
            key_reg  <= items.data.key;
            tag_reg  <= items.data.tag;
        end
        if (pop_do)
        begin
            od_reg <= word;
        end
    end

    // reservoir store, written in arrival order
    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[rcnt_reg[SLOT_W-1:0]] <= {key_reg, tag_reg};
        end
        res_rd_reg <= res_mem[idx_reg[SLOT_W-1:0]];
    end

endmodule

`default_nettype wire

// ===== sv/nsrg_checker.sv =====
// ---------------------------------------------------------------------------
// nsrg_checker
// port level checks of the run generator, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nsrg_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_last
);

    // a stalled word stays offered
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // one item at a time: ready drops after an accept
    `ASSERT_NEXT(a_in_one, in_valid && in_ready, !in_ready)
    // a stalled word keeps its end-of-item mark
    `ASSERT_NEXT(a_last_stable, out_valid && !out_ready, $stable(out_last))

endmodule

bind natural_selection_run_generator nsrg_checker u_nsrg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_last  (results.data.last)
);

`default_nettype wire
